// ----- src/ppt_pkg.sv -----
// ppt_pkg: shared constants, types and helpers of the planar projective transform
package ppt_pkg;

	// point and coefficient formats
	localparam int PIXEL_INT_BITS = 12;
	localparam int OUT_FRAC_BITS  = 12;
	localparam int PIX_W          = 16;
	localparam int COEF_W         = 32;
	localparam int OUT_W          = 16;
	localparam int NUM_REGS       = 8;
	localparam int CFG_IDX_W      = $clog2(NUM_REGS);
	localparam int PIX_FRAC       = PIX_W - PIXEL_INT_BITS;

	// datapath widths
	localparam int PROD_W = COEF_W + PIX_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int MAG_W  = SUM_W;

	// scale shifts
	localparam int OFF_SHIFT = 8 + PIX_FRAC;
	localparam int ONE_SHIFT = 40 + PIX_FRAC;
	localparam int EPS_SHIFT = 17 + PIX_FRAC;

	// divider: quotient bits kept and pre-shift of the numerator
	localparam int FRAC_STEPS = 8 + OUT_FRAC_BITS + 1;
	localparam int QB         = OUT_W + 1;
	localparam int PRE_SHIFT  = FRAC_STEPS - QB;
	localparam int EXT_W      = MAG_W + PRE_SHIFT;
	localparam int DIV_STEPS  = QB;

	localparam logic signed [SUM_W-1:0] DEN_ONE     = SUM_W'(1) << ONE_SHIFT;
	localparam logic signed [SUM_W-1:0] DEN_EPS     = SUM_W'(1) << EPS_SHIFT;
	localparam logic signed [SUM_W-1:0] DEN_NEG_EPS = -DEN_EPS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIN_XX  = 3'd0,
		REG_LIN_XY  = 3'd1,
		REG_LIN_YX  = 3'd2,
		REG_LIN_YY  = 3'd3,
		REG_OFF_X   = 3'd4,
		REG_OFF_Y   = 3'd5,
		REG_PERSP_X = 3'd6,
		REG_PERSP_Y = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] lin_xx;
		logic signed [COEF_W-1:0] lin_xy;
		logic signed [COEF_W-1:0] lin_yx;
		logic signed [COEF_W-1:0] lin_yy;
		logic signed [COEF_W-1:0] off_x;
		logic signed [COEF_W-1:0] off_y;
		logic signed [COEF_W-1:0] persp_x;
		logic signed [COEF_W-1:0] persp_y;
	} coef_set_t;

	// one divider beat: both lanes share the denominator magnitude
	typedef struct packed {
		logic [MAG_W-1:0] rem_x;
		logic [MAG_W-1:0] rem_y;
		logic [QB-1:0]    quo_x;
		logic [QB-1:0]    quo_y;
		logic [MAG_W-1:0] den_mag;
		logic             neg_x;
		logic             neg_y;
		logic             ovf_x;
		logic             ovf_y;
		logic             degen;
	} div_data_t;

	typedef struct packed {
		logic      valid;
		div_data_t data;
	} div_beat_t;

	function automatic logic signed [PROD_W-1:0] mul_coef_pix(
		input logic signed [COEF_W-1:0] c,
		input logic [PIX_W-1:0]         p
	);
		logic signed [PROD_W-1:0] ce;
		logic signed [PROD_W-1:0] pe;
		ce = {{(PROD_W-COEF_W){c[COEF_W-1]}}, c};
		pe = {{(PROD_W-PIX_W){1'b0}}, p};
		return ce * pe;
	endfunction

	function automatic logic signed [SUM_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
		return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	function automatic logic signed [SUM_W-1:0] off_term(input logic signed [COEF_W-1:0] c);
		logic signed [SUM_W-1:0] e;
		e = {{(SUM_W-COEF_W){c[COEF_W-1]}}, c};
		return e <<< OFF_SHIFT;
	endfunction

	function automatic logic [MAG_W-1:0] abs_val(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

// ----- src/ppt_cfg_regs.sv -----
// ppt_cfg_regs: homography coefficient registers behind the write port
module ppt_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppt_pkg::COEF_W-1:0]     cfg_data,
	output ppt_pkg::coef_set_t             coefs
);
	import ppt_pkg::*;

	coef_set_t coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_LIN_XX:  coefs_q.lin_xx  <= cfg_data;
				REG_LIN_XY:  coefs_q.lin_xy  <= cfg_data;
				REG_LIN_YX:  coefs_q.lin_yx  <= cfg_data;
				REG_LIN_YY:  coefs_q.lin_yy  <= cfg_data;
				REG_OFF_X:   coefs_q.off_x   <= cfg_data;
				REG_OFF_Y:   coefs_q.off_y   <= cfg_data;
				REG_PERSP_X: coefs_q.persp_x <= cfg_data;
				REG_PERSP_Y: coefs_q.persp_y <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

// ----- src/ppt_front.sv -----
// ppt_front: products, sums, magnitudes and divider setup (four stages)
module ppt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [ppt_pkg::PIX_W-1:0]   pixel_x,
	input  logic [ppt_pkg::PIX_W-1:0]   pixel_y,
	input  ppt_pkg::coef_set_t          coefs,
	output ppt_pkg::div_beat_t          beat
);
	import ppt_pkg::*;

	// stage 1: six products
	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_xx_s1, prod_xy_s1, prod_yx_s1, prod_yy_s1;
	logic signed [PROD_W-1:0] prod_px_s1, prod_py_s1;
	// stage 2: numerators and denominator
	logic                     valid_s2;
	logic signed [SUM_W-1:0]  num_x_s2, num_y_s2, den_s2;
	// stage 3: magnitudes and signs
	logic                     valid_s3;
	logic [MAG_W-1:0]         mag_x_s3, mag_y_s3, den_mag_s3;
	logic                     neg_x_s3, neg_y_s3, degen_s3;
	// stage 4: divider setup
	logic                     valid_s4;
	div_data_t                data_s4;

	logic [EXT_W-1:0] ext_x, ext_y, ext_d;
	logic             ovf_x, ovf_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_xx_s1 <= mul_coef_pix(coefs.lin_xx, pixel_x);
		prod_xy_s1 <= mul_coef_pix(coefs.lin_xy, pixel_y);
		prod_yx_s1 <= mul_coef_pix(coefs.lin_yx, pixel_x);
		prod_yy_s1 <= mul_coef_pix(coefs.lin_yy, pixel_y);
		prod_px_s1 <= mul_coef_pix(coefs.persp_x, pixel_x);
		prod_py_s1 <= mul_coef_pix(coefs.persp_y, pixel_y);
	end

	always_ff @(posedge clk) begin
		num_x_s2 <= ext_prod(prod_xx_s1) + ext_prod(prod_xy_s1) + off_term(coefs.off_x);
		num_y_s2 <= ext_prod(prod_yx_s1) + ext_prod(prod_yy_s1) + off_term(coefs.off_y);
		den_s2   <= ext_prod(prod_px_s1) + ext_prod(prod_py_s1) + DEN_ONE;
	end

	always_ff @(posedge clk) begin
		mag_x_s3   <= abs_val(num_x_s2);
		mag_y_s3   <= abs_val(num_y_s2);
		den_mag_s3 <= abs_val(den_s2);
		neg_x_s3   <= num_x_s2[SUM_W-1] ^ den_s2[SUM_W-1];
		neg_y_s3   <= num_y_s2[SUM_W-1] ^ den_s2[SUM_W-1];
		degen_s3   <= (den_s2 <= DEN_EPS) && (den_s2 >= DEN_NEG_EPS);
	end

	// quotient would not fit the kept bits: saturates for sure
	always_comb begin
		ext_x = EXT_W'(mag_x_s3) << PRE_SHIFT;
		ext_y = EXT_W'(mag_y_s3) << PRE_SHIFT;
		ext_d = EXT_W'(den_mag_s3);
		ovf_x = ext_x >= ext_d;
		ovf_y = ext_y >= ext_d;
	end

	always_ff @(posedge clk) begin
		data_s4.rem_x   <= ovf_x ? '0 : ext_x[MAG_W-1:0];
		data_s4.rem_y   <= ovf_y ? '0 : ext_y[MAG_W-1:0];
		data_s4.quo_x   <= '0;
		data_s4.quo_y   <= '0;
		data_s4.den_mag <= den_mag_s3;
		data_s4.neg_x   <= neg_x_s3;
		data_s4.neg_y   <= neg_y_s3;
		data_s4.ovf_x   <= ovf_x;
		data_s4.ovf_y   <= ovf_y;
		data_s4.degen   <= degen_s3;
	end

	assign beat.valid = valid_s4;
	assign beat.data  = data_s4;

endmodule

// ----- src/ppt_div_step.sv -----
// ppt_div_step: one registered restoring-division step for both coordinates
module ppt_div_step (
	input  logic                clk,
	input  logic                arst_n,
	input  ppt_pkg::div_beat_t  beat_in,
	output ppt_pkg::div_beat_t  beat_out
);
	import ppt_pkg::*;

	logic      valid_q;
	div_data_t data_q;
	div_data_t data_next;

	logic [MAG_W:0] dbl_x, dbl_y, den_ext, dif_x, dif_y;
	logic           ge_x, ge_y;

	always_comb begin
		den_ext = {1'b0, beat_in.data.den_mag};
		dbl_x   = {beat_in.data.rem_x, 1'b0};
		dbl_y   = {beat_in.data.rem_y, 1'b0};
		dif_x   = dbl_x - den_ext;
		dif_y   = dbl_y - den_ext;
		ge_x    = dbl_x >= den_ext;
		ge_y    = dbl_y >= den_ext;

		data_next       = beat_in.data;
		data_next.rem_x = ge_x ? dif_x[MAG_W-1:0] : dbl_x[MAG_W-1:0];
		data_next.rem_y = ge_y ? dif_y[MAG_W-1:0] : dbl_y[MAG_W-1:0];
		data_next.quo_x = {beat_in.data.quo_x[QB-2:0], ge_x};
		data_next.quo_y = {beat_in.data.quo_y[QB-2:0], ge_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

	assign beat_out.valid = valid_q;
	assign beat_out.data  = data_q;

endmodule

// ----- src/planar_projective_transform.sv -----
// planar_projective_transform: top level, pixel point to field coordinates
//
// maps a pixel point (unsigned q12.4) to field meters (signed q3.12) through a
// homography with h22 fixed at one: x and y numerators over the common
// perspective denominator, rounded to nearest (ties away from zero) and
// saturated to 16 bits, with clipped set when either coordinate saturated.
// a denominator within 2^-23 of zero gives (0,0) with degenerate set.
// all-zero coefficients (the reset state) give (0,0) with both flags clear.
// one point is taken every clock (busy never rises); its result shows on the
// outputs with done high for one cycle, after one stage of multipliers, one of
// sums, one of magnitudes, one of divider setup, seventeen restoring-division
// steps (one quotient bit each) and the rounding/saturation output stage. the
// receiver cannot stall, so nothing ever backs up. the user must write
// coefficients only while no point is in flight; the block does not enforce it.
module planar_projective_transform (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppt_pkg::COEF_W-1:0]         cfg_data,
	// input beat
	input  logic                               start,
	output logic                               busy,
	input  logic [ppt_pkg::PIX_W-1:0]          pixel_x,
	input  logic [ppt_pkg::PIX_W-1:0]          pixel_y,
	// result beat
	output logic                               done,
	output logic signed [ppt_pkg::OUT_W-1:0]   field_x,
	output logic signed [ppt_pkg::OUT_W-1:0]   field_y,
	output logic                               degenerate,
	output logic                               clipped
);
	import ppt_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             sat;
	} lane_res_t;

	localparam logic [QB-1:0] MAG_POS_MAX = QB'(2 ** (OUT_W - 1) - 1);
	localparam logic [QB-1:0] MAG_NEG_MAX = QB'(2 ** (OUT_W - 1));
	localparam logic [OUT_W-1:0] OUT_POS_SAT = OUT_W'(2 ** (OUT_W - 1) - 1);
	localparam logic [OUT_W-1:0] OUT_NEG_SAT = OUT_W'(2 ** (OUT_W - 1));

	coef_set_t coefs;
	logic      in_beat;

	// divider chain: beat 0 from the front end, one step per entry after that
	div_beat_t div_chain [DIV_STEPS+1];

	logic                    done_s22;
	logic signed [OUT_W-1:0] field_x_s22, field_y_s22;
	logic                    degenerate_s22, clipped_s22;

	lane_res_t res_x, res_y;
	div_data_t last;

	// round the kept quotient (one extra bit) to nearest, then apply sign and limits
	function automatic lane_res_t finish_lane(
		input logic [QB-1:0] quo,
		input logic          neg,
		input logic          ovf
	);
		logic [QB:0]   inc;
		logic [QB-1:0] mag;
		lane_res_t     r;
		inc = {1'b0, quo} + 1'b1;
		mag = inc[QB:1];
		if (neg) begin
			if (ovf || (mag > MAG_NEG_MAX)) begin
				r.value = OUT_NEG_SAT;
				r.sat   = 1'b1;
			end else begin
				r.value = OUT_W'(~mag + 1'b1);
				r.sat   = 1'b0;
			end
		end else begin
			if (ovf || (mag > MAG_POS_MAX)) begin
				r.value = OUT_POS_SAT;
				r.sat   = 1'b1;
			end else begin
				r.value = mag[OUT_W-1:0];
				r.sat   = 1'b0;
			end
		end
		return r;
	endfunction

	// no back pressure anywhere: every start is taken
	assign busy    = 1'b0;
	assign in_beat = start && !busy;

	ppt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	ppt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_beat),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.coefs    (coefs),
		.beat     (div_chain[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		ppt_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.beat_in  (div_chain[i]),
			.beat_out (div_chain[i+1])
		);
	end

	// output stage: rounding, saturation, degenerate override
	always_comb begin
		last  = div_chain[DIV_STEPS].data;
		res_x = finish_lane(last.quo_x, last.neg_x, last.ovf_x);
		res_y = finish_lane(last.quo_y, last.neg_y, last.ovf_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s22 <= 1'b0;
		end else begin
			done_s22 <= div_chain[DIV_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (last.degen) begin
			// near-zero denominator: zero point, flag only degenerate
			field_x_s22    <= '0;
			field_y_s22    <= '0;
			degenerate_s22 <= 1'b1;
			clipped_s22    <= 1'b0;
		end else begin
			field_x_s22    <= res_x.value;
			field_y_s22    <= res_y.value;
			degenerate_s22 <= 1'b0;
			clipped_s22    <= res_x.sat | res_y.sat;
		end
	end

	assign done       = done_s22;
	assign field_x    = field_x_s22;
	assign field_y    = field_y_s22;
	assign degenerate = degenerate_s22;
	assign clipped    = clipped_s22;

endmodule

// ----- tb/ppt_result_checker.sv -----
// ppt_result_checker: predicts and checks every result beat of the planar projective transform
module ppt_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppt_pkg::COEF_W-1:0]       cfg_data,
	input  logic                             start,
	input  logic                             busy,
	input  logic [ppt_pkg::PIX_W-1:0]        pixel_x,
	input  logic [ppt_pkg::PIX_W-1:0]        pixel_y,
	input  logic                             done,
	input  logic signed [ppt_pkg::OUT_W-1:0] field_x,
	input  logic signed [ppt_pkg::OUT_W-1:0] field_y,
	input  logic                             degenerate,
	input  logic                             clipped,
	output int                               mismatch_count,
	output int                               points_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;
	import ppt_pkg::*;

	localparam int     QUO_STEPS   = OUT_FRAC_BITS + 9;
	localparam longint OFF_SCALE   = 64'sd1 <<< (8 + PIX_FRAC);
	localparam longint DEN_UNIT    = 64'sd1 <<< (40 + PIX_FRAC);
	localparam longint DEN_FLOOR   = 64'sd1 <<< (17 + PIX_FRAC);

	typedef struct packed {
		logic signed [OUT_W-1:0] fx;
		logic signed [OUT_W-1:0] fy;
		logic                    degen;
		logic                    clip;
	} field_pt_t;

	coef_set_t cal;
	field_pt_t field_q[$];

	// rounded, saturated num * 2^(8+frac) / den; top bit flags saturation
	function automatic logic [OUT_W:0] scaled_quotient(input longint num, input longint den);
		bit        neg;
		bit [63:0] an, ad, q, r, mag;
		int        i;
		neg = (num < 0) != (den < 0);
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q = an / ad;
		r = an % ad;
		if (q > 64'd65535) begin
			mag = 64'd65536;
		end else begin
			for (i = 0; i < QUO_STEPS; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= ad) begin
					r = r - ad;
					q[0] = 1'b1;
				end
			end
			mag = (q + 64'd1) >> 1;
		end
		if (neg) begin
			if (mag > 64'd32768)
				return {1'b1, 16'h8000};
			return {1'b0, OUT_W'(64'd0 - mag)};
		end
		if (mag > 64'd32767)
			return {1'b1, 16'h7FFF};
		return {1'b0, mag[OUT_W-1:0]};
	endfunction

	function automatic field_pt_t project_point(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
		longint         x, y, nx, ny, den;
		logic [OUT_W:0] qx, qy;
		field_pt_t      res;
		x = longint'(px);
		y = longint'(py);
		nx = longint'(cal.lin_xx) * x + longint'(cal.lin_xy) * y + longint'(cal.off_x) * OFF_SCALE;
		ny = longint'(cal.lin_yx) * x + longint'(cal.lin_yy) * y + longint'(cal.off_y) * OFF_SCALE;
		den = longint'(cal.persp_x) * x + longint'(cal.persp_y) * y + DEN_UNIT;
		if (den <= DEN_FLOOR && den >= -DEN_FLOOR) begin
			res = '{fx: '0, fy: '0, degen: 1'b1, clip: 1'b0};
		end else begin
			qx = scaled_quotient(nx, den);
			qy = scaled_quotient(ny, den);
			res.fx = qx[OUT_W-1:0];
			res.fy = qy[OUT_W-1:0];
			res.degen = 1'b0;
			res.clip = qx[OUT_W] | qy[OUT_W];
		end
		return res;
	endfunction

	task automatic note_mismatch(input string what, input logic signed [OUT_W:0] want_v,
		input logic signed [OUT_W:0] got_v);
		mismatch_count++;
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		field_pt_t want;
		if (!arst_n) begin
			cal = '0;
			field_q.delete();
			points_in_flight = 0;
		end else begin
			if (done) begin
				if (field_q.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: result beat with no point in flight, expected none, actual (%0d,%0d)",
						$time, field_x, field_y);
				end else begin
					want = field_q.pop_front();
					if (field_x !== want.fx)
						note_mismatch("field_x", (OUT_W+1)'(want.fx), (OUT_W+1)'(field_x));
					if (field_y !== want.fy)
						note_mismatch("field_y", (OUT_W+1)'(want.fy), (OUT_W+1)'(field_y));
					if (degenerate !== want.degen)
						note_mismatch("degenerate", (OUT_W+1)'(want.degen), (OUT_W+1)'(degenerate));
					if (clipped !== want.clip)
						note_mismatch("clipped", (OUT_W+1)'(want.clip), (OUT_W+1)'(clipped));
				end
			end
			// point beats use the coefficients already in place at this edge
			if (start && !busy)
				field_q.push_back(project_point(pixel_x, pixel_y));
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_index))
					REG_LIN_XX:  cal.lin_xx  = cfg_data;
					REG_LIN_XY:  cal.lin_xy  = cfg_data;
					REG_LIN_YX:  cal.lin_yx  = cfg_data;
					REG_LIN_YY:  cal.lin_yy  = cfg_data;
					REG_OFF_X:   cal.off_x   = cfg_data;
					REG_OFF_Y:   cal.off_y   = cfg_data;
					REG_PERSP_X: cal.persp_x = cfg_data;
					REG_PERSP_Y: cal.persp_y = cfg_data;
					default: ;
				endcase
			end
			points_in_flight = field_q.size();
		end
	end

endmodule

// ----- tb/planar_projective_transform_tb.sv -----
// planar_projective_transform_tb: stimulus, watchdog and verdict for the planar projective transform
module planar_projective_transform_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppt_pkg::*;

	// kinds of random calibration
	typedef enum int {
		CAL_CAMERA,   // realistic gains, offsets and mild perspective
		CAL_WIDE,     // log-uniform magnitudes over the full 32-bit range
		CAL_HORIZON   // horizon line placed inside the image, so points land on it
	} cal_style_t;

	localparam int WATCHDOG_LIMIT = 1000;
	// extra wait after the last result beat, as margin
	localparam int SETTLE_CYCLES  = 24;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_POINTS   = 225;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [COEF_W-1:0]       cfg_data = '0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [PIX_W-1:0]        pixel_x = '0;
	logic [PIX_W-1:0]        pixel_y = '0;
	logic                    done;
	logic signed [OUT_W-1:0] field_x;
	logic signed [OUT_W-1:0] field_y;
	logic                    degenerate;
	logic                    clipped;
	int                      mismatch_count;
	int                      points_in_flight;
	int                      idle_cycles = 0;

	always #5 clk = ~clk;

	planar_projective_transform DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.done       (done),
		.field_x    (field_x),
		.field_y    (field_y),
		.degenerate (degenerate),
		.clipped    (clipped)
	);

	// the checker watches both beat channels and the register port
	ppt_result_checker field_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.start            (start),
		.busy             (busy),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.done             (done),
		.field_x          (field_x),
		.field_y          (field_y),
		.degenerate       (degenerate),
		.clipped          (clipped),
		.mismatch_count   (mismatch_count),
		.points_in_flight (points_in_flight)
	);

	// watchdog: any cycle without a point beat or a result beat counts toward the limit
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one point beat: drive at the falling edge, hold until taken at a rising edge
	task automatic send_point(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
		@(negedge clk);
		start <= 1'b1;
		pixel_x <= px;
		pixel_y <= py;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// stop sending and wait until every result beat has come back
	task automatic drain_points();
		@(negedge clk);
		start <= 1'b0;
		wait (points_in_flight == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write enable stays high across back-to-back register writes
	task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic load_coefs(input coef_set_t cs);
		write_reg(REG_LIN_XX, cs.lin_xx);
		write_reg(REG_LIN_XY, cs.lin_xy);
		write_reg(REG_LIN_YX, cs.lin_yx);
		write_reg(REG_LIN_YY, cs.lin_yy);
		write_reg(REG_OFF_X, cs.off_x);
		write_reg(REG_OFF_Y, cs.off_y);
		write_reg(REG_PERSP_X, cs.persp_x);
		write_reg(REG_PERSP_Y, cs.persp_y);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// uniform magnitude up to lim with a random sign
	function automatic logic [COEF_W-1:0] rand_near(input int unsigned lim);
		logic [COEF_W-1:0] v;
		v = $urandom_range(0, lim);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// log-uniform magnitude, now and then pinned to either extreme
	function automatic logic [COEF_W-1:0] rand_wide();
		logic [COEF_W-1:0] v;
		case ($urandom_range(0, 15))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic random_coefs(input cal_style_t style, output coef_set_t cs, output int focus);
		longint q;
		focus = 0;
		cs.lin_xx = rand_near(1 << 25);
		cs.lin_xy = rand_near(1 << 25);
		cs.lin_yx = rand_near(1 << 25);
		cs.lin_yy = rand_near(1 << 25);
		cs.off_x = rand_near(1 << 26);
		cs.off_y = rand_near(1 << 26);
		cs.persp_x = rand_near(1 << 27);
		cs.persp_y = rand_near(1 << 27);
		case (style)
			CAL_WIDE: begin
				cs = '{rand_wide(), rand_wide(), rand_wide(), rand_wide(),
					rand_wide(), rand_wide(), rand_wide(), rand_wide()};
			end
			CAL_HORIZON: begin
				// denominator crosses zero at pixel column focus; the residue there
				// stays far below the near-zero band
				focus = $urandom_range(8192, 65535);
				q = ((64'sd1 <<< (40 + PIX_FRAC)) + focus / 2) / focus;
				cs.persp_x = COEF_W'(-q);
				cs.persp_y = rand_near(64);
			end
			default: ;
		endcase
	endtask

	task automatic pick_point(input cal_style_t style, input int focus,
		output logic [PIX_W-1:0] px, output logic [PIX_W-1:0] py);
		int sel;
		int t;
		sel = $urandom_range(0, 99);
		px = PIX_W'($urandom);
		py = PIX_W'($urandom);
		if (style == CAL_HORIZON && sel < 30) begin
			// right on the horizon: degenerate
			px = PIX_W'(focus);
			py = PIX_W'($urandom_range(0, 255));
		end else if (style == CAL_HORIZON && sel < 55) begin
			// just beside it: huge quotients of either sign
			t = focus - 8 + int'($urandom_range(0, 16));
			px = (t > 65535) ? 16'hFFFF : PIX_W'(t);
			py = PIX_W'($urandom_range(0, 255));
		end else if (sel >= 85) begin
			px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			py = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		end
	endtask

	// sender bursts of random length with random gaps, or back to back
	task automatic run_points(input cal_style_t style, input int focus, input int count,
		input bit back_to_back);
		int left;
		int burst;
		int g;
		logic [PIX_W-1:0] px, py;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && left > 0) begin
				pick_point(style, focus, px, py);
				send_point(px, py);
				burst--;
				left--;
			end
			if (!back_to_back) begin
				g = $urandom_range(0, 9);
				pause_sender(g < 3 ? 0 : (g == 9 ? $urandom_range(10, 20) : $urandom_range(1, 4)));
			end
		end
	endtask

	initial begin
		coef_set_t  cs;
		cal_style_t style;
		int         focus;
		int         ph;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// uncalibrated: all-zero coefficients map everything to the origin
		send_point(16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF);
		send_point(16'hFFFF, 16'h0000);
		send_point(16'h0000, 16'hFFFF);
		drain_points();

		// half-step quotients: ties round away from zero
		cs = '{32'sh0080_0000, 0, 32'shFF80_0000, 0, 0, 0, 0, 0};
		load_coefs(cs);
		send_point(16'd1, 16'd0);
		send_point(16'd3, 16'd0);
		send_point(16'd0, 16'd7);
		drain_points();

		// exact output limits and one step past them
		cs = '{32'sh8000_0000, 0, 0, 32'sh01FF_FC00, 0, 0, 0, 0};
		load_coefs(cs);
		send_point(16'd256, 16'd0);
		send_point(16'd257, 16'd0);
		send_point(16'd0, 16'd16384);
		send_point(16'd0, 16'd16385);
		drain_points();

		// denominator exactly zero, at +2^-23, and just above it; extreme gains
		cs = '{32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'shC000_0000, 32'sh0000_0040};
		load_coefs(cs);
		send_point(16'd16384, 16'd0);
		send_point(16'd16384, 16'd32768);
		send_point(16'd16384, 16'd32769);
		send_point(16'd0, 16'd0);
		send_point(16'hFFFF, 16'hFFFF);
		drain_points();

		// denominator at -2^-23 and just below it
		cs = '{0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh0000_1000, 32'sh0000_1000,
			32'shC000_0000, 32'shFFFF_FFC0};
		load_coefs(cs);
		send_point(16'd16384, 16'd32768);
		send_point(16'd16384, 16'd32769);
		send_point(16'd1, 16'd1);
		drain_points();

		// random calibrations, each followed by a full drain before the next load
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			style = cal_style_t'(ph % 3);
			random_coefs(style, cs, focus);
			load_coefs(cs);
			if (ph == 4) begin
				// sender holds off mid-phase until the pipeline is empty
				run_points(style, focus, PHASE_POINTS / 2, 1'b0);
				drain_points();
				run_points(style, focus, PHASE_POINTS - PHASE_POINTS / 2, 1'b0);
			end else begin
				run_points(style, focus, PHASE_POINTS, ph == 3);
			end
			drain_points();
		end

		if (mismatch_count == 0 && points_in_flight == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
